### rtl/spot_light_radiance_assert.svh
// Assertion macros used by the spot light radiance RTL.
`ifndef SPOT_LIGHT_RADIANCE_ASSERT_SVH
`define SPOT_LIGHT_RADIANCE_ASSERT_SVH

// Condition implies property in the same cycle.
`define SLR_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("spot light radiance check failed");

// Condition implies property in the next cycle.
`define SLR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("spot light radiance check failed");

`endif

### rtl/slr_pkg.sv
package slr_pkg;

    localparam int IN_W        = 96;
    localparam int OUT_W       = 48;
    localparam int CFG_W       = 48;
    localparam int CFG_AW      = 3;
    localparam int SQ_IN_W     = 34;
    localparam int SQ_W        = 36;
    localparam int ROOT_W      = 17;
    localparam int SQRT_STAGES = 17;
    localparam int DIV_W       = 44;
    localparam int DIV_STAGES  = 17;
    localparam int LATENCY     = 79;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_POSITION  = 3'd1,
        CFG_AXIS      = 3'd2,
        CFG_COLOR     = 3'd3,
        CFG_INTENSITY = 3'd4,
        CFG_ATTEN     = 3'd5,
        CFG_RANGE     = 3'd6,
        CFG_CONES     = 3'd7
    } t_cfg_idx;

endpackage

### rtl/spot_light_radiance.sv
// Spot light radiance: one shading point in, one RGB radiance out.
// Input channel (i_s_*): one transfer carries a surface point (Q8.8) and its
// unit normal (Q1.14). Output channel (o_m_*): one transfer carries the
// saturated red, green and blue radiance (Q8.8) and the inside-cone flag.
// The user must set the light through the register write port only while no
// point is in flight; the block does not enforce this. Each write takes effect at the clock edge of the write enable.
// The pipeline is 79 stages deep. One point is taken every cycle unless the
// receiver stalls with a result waiting. The depth is set by the square root
// (17 stages), the unit direction divide (17 stages), the falloff divide
// (17 stages) and the radiance divide (17 stages), plus eleven stages of
// multiply, sum and select.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and the input channel is not ready; nothing is dropped or repeated.
// Reset empties the pipeline and loads the register defaults: light on,
// unit intensity, constant attenuation of one, no range limit.
`include "spot_light_radiance_assert.svh"

module spot_light_radiance (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z
    input  logic [slr_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // radiance_red, radiance_green, radiance_blue
    output logic [slr_pkg::OUT_W-1:0]   o_m_tdata,
    // inside_cone
    output logic                        o_m_tuser,
    input  logic                        i_cfg_we,
    input  logic [slr_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [slr_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam int LAT = slr_pkg::LATENCY;
    localparam int SQS = slr_pkg::SQRT_STAGES;
    localparam int DVS = slr_pkg::DIV_STAGES;
    localparam int DW  = slr_pkg::DIV_W;

    typedef struct packed {
        logic [2:0][16:0] v;
        logic [2:0][15:0] nrm;
        logic [33:0]      d2;
        logic             far;
    } t_sq_side;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][15:0] nrm;
        logic             far;
        logic             dz;
        logic [32:0]      m1;
        logic [49:0]      m2;
    } t_ud_side;

    typedef struct packed {
        logic             dark;
        logic             full;
        logic [2:0][26:0] t1;
        logic [DW-1:0]    den;
    } t_fd_side;

    typedef struct packed {
        logic       dark;
        logic [2:0] sat;
        logic [2:0] zero;
    } t_rd_side;

    logic        r_light_enable;
    logic [47:0] r_light_position;
    logic [47:0] r_spot_axis;
    logic [47:0] r_light_color;
    logic [15:0] r_light_intensity;
    logic [47:0] r_atten;
    logic [15:0] r_range_limit;
    logic [31:0] r_cone_cosines;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_enable    <= 1'b1;
            r_light_position  <= '0;
            r_spot_axis       <= '0;
            r_light_color     <= '0;
            r_light_intensity <= 16'd256;
            r_atten           <= 48'd256;
            r_range_limit     <= '0;
            r_cone_cosines    <= '0;
        end else if (i_cfg_we) begin
            case (slr_pkg::t_cfg_idx'(i_cfg_addr))
                slr_pkg::CFG_ENABLE:    r_light_enable    <= i_cfg_wdata[0];
                slr_pkg::CFG_POSITION:  r_light_position  <= i_cfg_wdata;
                slr_pkg::CFG_AXIS:      r_spot_axis       <= i_cfg_wdata;
                slr_pkg::CFG_COLOR:     r_light_color     <= i_cfg_wdata;
                slr_pkg::CFG_INTENSITY: r_light_intensity <= i_cfg_wdata[15:0];
                slr_pkg::CFG_ATTEN:     r_atten           <= i_cfg_wdata;
                slr_pkg::CFG_RANGE:     r_range_limit     <= i_cfg_wdata[15:0];
                slr_pkg::CFG_CONES:     r_cone_cosines    <= i_cfg_wdata[31:0];
                default:                r_light_enable    <= r_light_enable;
            endcase
        end
    end

    assign w_en       = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Stages A to C: vector to the light and its squared length.
    logic signed [16:0] r_a_v [3];
    logic signed [16:0] r_b_v [3];
    logic signed [16:0] r_c_v [3];
    logic [15:0]        r_a_nrm [3];
    logic [15:0]        r_b_nrm [3];
    logic [15:0]        r_c_nrm [3];
    logic [33:0]        r_b_sq [3];
    logic [33:0]        r_c_d2;
    logic signed [33:0] w_sq [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq[i] = 34'(r_a_v[i]) * 34'(r_a_v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_v[i]   <= 17'(signed'(r_light_position[16*i +: 16]))
                            - 17'(signed'(i_s_tdata[16*i +: 16]));
                r_a_nrm[i] <= i_s_tdata[48 + 16*i +: 16];
                r_b_sq[i]  <= 34'(unsigned'(w_sq[i]));
                r_b_v[i]   <= r_a_v[i];
                r_b_nrm[i] <= r_a_nrm[i];
                r_c_v[i]   <= r_b_v[i];
                r_c_nrm[i] <= r_b_nrm[i];
            end
            r_c_d2 <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        end
    end

    // Square root, with the rest of the item alongside.
    logic [31:0]               w_rng_sq;
    t_sq_side                  w_sq_entry;
    t_sq_side                  r_sq_side [SQS];
    logic [slr_pkg::ROOT_W-1:0] w_root;

    always_comb begin
        w_rng_sq = r_range_limit * r_range_limit;
        for (int i = 0; i < 3; i++) begin
            w_sq_entry.v[i]   = unsigned'(r_c_v[i]);
            w_sq_entry.nrm[i] = r_c_nrm[i];
        end
        w_sq_entry.d2  = r_c_d2;
        w_sq_entry.far = (r_range_limit != 16'd0) && (r_c_d2 > 34'(w_rng_sq));
    end

    slr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_c_d2),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= w_sq_entry;
            for (int k = 1; k < SQS; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // Stage D: divide operands for the unit direction, attenuation products.
    logic [DW-1:0] r_d_num [3];
    logic [16:0]   r_d_d;
    t_ud_side      r_d_side;

    always_ff @(posedge i_clk) begin
        logic signed [16:0] vv;
        logic [16:0]        mag;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                vv  = signed'(r_sq_side[SQS-1].v[i]);
                mag = (vv < 0) ? unsigned'(-vv) : unsigned'(vv);
                r_d_num[i]      <= DW'({mag, 14'd0}) + DW'(w_root >> 1);
                r_d_side.neg[i] <= vv[16];
                r_d_side.nrm[i] <= r_sq_side[SQS-1].nrm[i];
            end
            r_d_d       <= w_root;
            r_d_side.far <= r_sq_side[SQS-1].far;
            r_d_side.dz  <= (w_root == '0);
            r_d_side.m1  <= r_atten[31:16] * w_root;
            r_d_side.m2  <= r_atten[47:32] * r_sq_side[SQS-1].d2;
        end
    end

    logic [DVS-1:0] w_uq [3];
    t_ud_side       r_ud_side [DVS];

    for (genvar g = 0; g < 3; g++) begin : g_udiv
        slr_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_d_num[g]),
            .i_den  (DW'(r_d_d)),
            .o_quot (w_uq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ud_side[0] <= r_d_side;
            for (int k = 1; k < DVS; k++) begin
                r_ud_side[k] <= r_ud_side[k-1];
            end
        end
    end

    // Stage E: signed unit direction, attenuation denominator, color scale.
    logic signed [15:0] r_e_u [3];
    logic [15:0]        r_e_nrm [3];
    logic [23:0]        r_e_t0 [3];
    logic [DW-1:0]      r_e_den;
    logic               r_e_far;
    t_ud_side           w_ud_out;

    assign w_ud_out = r_ud_side[DVS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_ud_out.dz) begin
                    r_e_u[i] <= '0;
                end else if (w_ud_out.neg[i]) begin
                    r_e_u[i] <= -signed'(w_uq[i][15:0]);
                end else begin
                    r_e_u[i] <= signed'(w_uq[i][15:0]);
                end
                r_e_nrm[i] <= w_ud_out.nrm[i];
                r_e_t0[i]  <= 24'((32'(r_light_color[16*i +: 16] * r_light_intensity)
                            + 32'd128) >> 8);
            end
            r_e_den <= DW'({r_atten[15:0], 8'd0}) + DW'(w_ud_out.m1)
                     + DW'((w_ud_out.m2 + 50'd128) >> 8);
            r_e_far <= w_ud_out.far;
        end
    end

    // Stage F: dot product terms.
    logic signed [31:0] r_f_pa [3];
    logic signed [31:0] r_f_pn [3];
    logic [23:0]        r_f_t0 [3];
    logic [DW-1:0]      r_f_den;
    logic               r_f_far;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_pa[i] <= 32'(r_e_u[i]) * 32'(signed'(r_spot_axis[16*i +: 16]));
                r_f_pn[i] <= 32'(signed'(r_e_nrm[i])) * 32'(r_e_u[i]);
                r_f_t0[i] <= r_e_t0[i];
            end
            r_f_den <= r_e_den;
            r_f_far <= r_e_far;
        end
    end

    // Stage G: cone cosine and clamped N dot L.
    logic signed [33:0] w_sa;
    logic signed [33:0] w_sn;
    logic signed [33:0] w_cos;
    logic signed [33:0] w_ndl;
    logic signed [19:0] r_g_cos;
    logic [16:0]        r_g_ndl;
    logic [23:0]        r_g_t0 [3];
    logic [DW-1:0]      r_g_den;
    logic               r_g_far;

    always_comb begin
        w_sa  = 34'(r_f_pa[0]) + 34'(r_f_pa[1]) + 34'(r_f_pa[2]);
        w_sn  = 34'(r_f_pn[0]) + 34'(r_f_pn[1]) + 34'(r_f_pn[2]);
        w_cos = (-w_sa + 34'sd8192) >>> 14;
        w_ndl = (w_sn + 34'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_cos <= 20'(w_cos);
            r_g_ndl <= (w_ndl < 0) ? '0 : 17'(unsigned'(w_ndl));
            for (int i = 0; i < 3; i++) begin
                r_g_t0[i] <= r_f_t0[i];
            end
            r_g_den <= r_f_den;
            r_g_far <= r_f_far;
        end
    end

    // Stage H: cone tests, falloff divide operands, first color product.
    logic signed [15:0] w_outer;
    logic signed [15:0] w_inner;
    logic signed [20:0] w_cdiff;
    logic signed [16:0] w_cspan;
    logic [DW-1:0]      r_h_fnum;
    logic [DW-1:0]      r_h_fden;
    t_fd_side           w_fd_entry;
    t_fd_side           r_fd_side [DVS];
    t_fd_side           r_h_side;

    always_comb begin
        w_outer = signed'(r_cone_cosines[15:0]);
        w_inner = signed'(r_cone_cosines[31:16]);
        w_cdiff = 21'(r_g_cos) - 21'(w_outer);
        w_cspan = 17'(w_inner) - 17'(w_outer);
        w_fd_entry.dark = !r_light_enable || r_g_far || (r_g_cos < 20'(w_outer));
        w_fd_entry.full = !(r_g_cos < 20'(w_inner));
        for (int i = 0; i < 3; i++) begin
            w_fd_entry.t1[i] = 27'((41'(r_g_t0[i]) * 41'(r_g_ndl) + 41'd8192) >> 14);
        end
        w_fd_entry.den = r_g_den;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_fnum <= DW'({w_cdiff[16:0], 14'd0});
            r_h_fden <= DW'(unsigned'(w_cspan));
            r_h_side <= w_fd_entry;
        end
    end

    logic [DVS-1:0] w_fq;

    slr_div u_fall_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_h_fnum),
        .i_den  (r_h_fden),
        .o_quot (w_fq)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd_side[0] <= r_h_side;
            for (int k = 1; k < DVS; k++) begin
                r_fd_side[k] <= r_fd_side[k-1];
            end
        end
    end

    // Stage I: falloff applied.
    logic [14:0]   w_fall;
    logic [26:0]   r_i_t2 [3];
    logic [DW-1:0] r_i_den;
    logic          r_i_dark;
    t_fd_side      w_fd_out;

    assign w_fd_out = r_fd_side[DVS-1];

    always_comb begin
        if (w_fd_out.full || (w_fq > DVS'(16384))) begin
            w_fall = 15'd16384;
        end else begin
            w_fall = w_fq[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_i_t2[i] <= 27'((42'(w_fd_out.t1[i]) * 42'(w_fall) + 42'd8192) >> 14);
            end
            r_i_den  <= w_fd_out.den;
            r_i_dark <= w_fd_out.dark;
        end
    end

    // Stage J: saturation tests and radiance divide operands.
    logic [DW-1:0] r_j_num [3];
    logic [DW-1:0] r_j_den;
    t_rd_side      r_j_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_j_num[i]       <= DW'({r_i_t2[i], 16'd0});
                r_j_side.zero[i] <= (r_i_t2[i] == '0);
                r_j_side.sat[i]  <= (r_i_t2[i] != '0)
                                  && ((DW+1)'(r_i_t2[i]) >= {r_i_den, 1'b0});
            end
            r_j_den       <= r_i_den;
            r_j_side.dark <= r_i_dark;
        end
    end

    logic [DVS-1:0] w_rq [3];
    t_rd_side       r_rd_side [DVS];

    for (genvar g = 0; g < 3; g++) begin : g_rdiv
        slr_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_j_num[g]),
            .i_den  (r_j_den),
            .o_quot (w_rq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd_side[0] <= r_j_side;
            for (int k = 1; k < DVS; k++) begin
                r_rd_side[k] <= r_rd_side[k-1];
            end
        end
    end

    // Stage K: output register.
    logic [15:0] r_out [3];
    logic        r_out_inside;
    t_rd_side    w_rd_out;

    assign w_rd_out = r_rd_side[DVS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_rd_out.dark || w_rd_out.zero[i]) begin
                    r_out[i] <= '0;
                end else if (w_rd_out.sat[i] || w_rq[i][DVS-1]) begin
                    r_out[i] <= 16'hFFFF;
                end else begin
                    r_out[i] <= w_rq[i][15:0];
                end
            end
            r_out_inside <= !w_rd_out.dark;
        end
    end

    assign o_m_tdata = {r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser = r_out_inside;

    `SLR_ASSERT_SAME(a_light_only_in_cone, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tdata != '0), o_m_tuser)
    `SLR_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready, r_vld[0])
    `SLR_ASSERT_NEXT(a_stall_freezes_pipe, i_clk, i_rst_n,
        !o_s_tready, $stable(r_vld))

endmodule

### rtl/slr_sqrt.sv
module slr_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [slr_pkg::SQ_IN_W-1:0] i_val,
    output logic [slr_pkg::ROOT_W-1:0]  o_root
);

    localparam int S = slr_pkg::SQRT_STAGES;
    localparam int W = slr_pkg::SQ_W;

    logic [W-1:0] r_x [S];
    logic [W-1:0] r_r [S];
    logic [W-1:0] w_x_in [S];
    logic [W-1:0] w_r_in [S];
    logic [W-1:0] n_x [S];
    logic [W-1:0] n_r [S];

    always_comb begin
        w_x_in[0] = W'(i_val);
        w_r_in[0] = '0;
        for (int k = 1; k < S; k++) begin
            w_x_in[k] = r_x[k-1];
            w_r_in[k] = r_r[k-1];
        end
    end

    always_comb begin
        logic [W-1:0] bit_v;
        logic [W-1:0] trial;
        for (int k = 0; k < S; k++) begin
            bit_v = W'(1) << (2 * (S - 1 - k));
            trial = w_r_in[k] + bit_v;
            if (w_x_in[k] >= trial) begin
                n_x[k] = w_x_in[k] - trial;
                n_r[k] = (w_r_in[k] >> 1) + bit_v;
            end else begin
                n_x[k] = w_x_in[k];
                n_r[k] = w_r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < S; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_root = r_r[S-1][slr_pkg::ROOT_W-1:0];

endmodule

### rtl/slr_div.sv
module slr_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [slr_pkg::DIV_W-1:0]      i_num,
    input  logic [slr_pkg::DIV_W-1:0]      i_den,
    output logic [slr_pkg::DIV_STAGES-1:0] o_quot
);

    localparam int S = slr_pkg::DIV_STAGES;
    localparam int W = slr_pkg::DIV_W;

    logic [W-1:0] r_rem  [S];
    logic [W-1:0] r_den  [S];
    logic [S-1:0] r_quot [S];
    logic [W-1:0] w_rem_in  [S];
    logic [W-1:0] w_den_in  [S];
    logic [S-1:0] w_quot_in [S];
    logic [W-1:0] n_rem  [S];
    logic [S-1:0] n_quot [S];

    always_comb begin
        w_rem_in[0]  = i_num;
        w_den_in[0]  = i_den;
        w_quot_in[0] = '0;
        for (int k = 1; k < S; k++) begin
            w_rem_in[k]  = r_rem[k-1];
            w_den_in[k]  = r_den[k-1];
            w_quot_in[k] = r_quot[k-1];
        end
    end

    // One quotient bit per stage, most significant first.
    always_comb begin
        logic [W+S:0] diff;
        for (int k = 0; k < S; k++) begin
            diff = {(S+1)'(0), w_rem_in[k]} - ({(S+1)'(0), w_den_in[k]} << (S - 1 - k));
            if (!diff[W+S]) begin
                n_rem[k]  = diff[W-1:0];
                n_quot[k] = w_quot_in[k] | (S'(1) << (S - 1 - k));
            end else begin
                n_rem[k]  = w_rem_in[k];
                n_quot[k] = w_quot_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < S; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_den_in[k];
                r_quot[k] <= n_quot[k];
            end
        end
    end

    assign o_quot = r_quot[S-1];

endmodule

### verif/spot_light_radiance_checker.sv
module spot_light_radiance_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [slr_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [slr_pkg::OUT_W-1:0]   i_m_tdata,
    input  logic                        i_m_tuser,
    input  logic                        i_cfg_we,
    input  logic [slr_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [slr_pkg::CFG_W-1:0]   i_cfg_wdata,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        in_cone;
    } t_shade;

    logic        lit_on;
    logic [47:0] lamp_pos;
    logic [47:0] cone_axis;
    logic [47:0] lamp_color;
    logic [15:0] lamp_gain;
    logic [47:0] atten_k;
    logic [15:0] reach;
    logic [31:0] cone_cos;

    t_shade radiance_q[$];

    function automatic longint s16(logic [15:0] x);
        return longint'($signed(x));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned rnd_shr(longint unsigned x, int s);
        return (x + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic t_shade shade_point(logic [slr_pkg::IN_W-1:0] item);
        t_shade res;
        longint vec[3];
        longint dir[3];
        longint nrm[3];
        longint axs[3];
        longint acc;
        longint cosv;
        longint outer;
        longint inner;
        longint ndl;
        longint unsigned d2;
        longint unsigned dlen;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned fall;
        longint unsigned den;
        longint unsigned t;
        longint unsigned r;
        res = '0;
        if (!lit_on) return res;
        d2 = 0;
        for (int i = 0; i < 3; i++) begin
            vec[i] = s16(lamp_pos[16*i +: 16]) - s16(item[16*i +: 16]);
            d2 += longint'(vec[i] * vec[i]);
            nrm[i] = s16(item[48 + 16*i +: 16]);
            axs[i] = s16(cone_axis[16*i +: 16]);
        end
        dlen = int_sqrt(d2);
        for (int i = 0; i < 3; i++) begin
            if (dlen == 0) begin
                dir[i] = 0;
            end else begin
                mag = (vec[i] < 0) ? -vec[i] : vec[i];
                q = ((mag << 14) + (dlen >> 1)) / dlen;
                dir[i] = (vec[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
        if (reach != 0 && d2 > longint'(reach) * longint'(reach)) return res;
        acc = 0;
        for (int i = 0; i < 3; i++) acc += dir[i] * axs[i];
        cosv = (-acc + 8192) >>> 14;
        outer = s16(cone_cos[15:0]);
        inner = s16(cone_cos[31:16]);
        if (cosv < outer) return res;
        res.in_cone = 1'b1;
        fall = 16384;
        if (cosv < inner) begin
            fall = longint'(unsigned'(cosv - outer) << 14) / longint'(inner - outer);
            if (fall > 16384) fall = 16384;
        end
        acc = 0;
        for (int i = 0; i < 3; i++) acc += nrm[i] * dir[i];
        ndl = (acc + 8192) >>> 14;
        if (ndl < 0) ndl = 0;
        den = (longint'(atten_k[15:0]) << 8) + longint'(atten_k[31:16]) * dlen
            + rnd_shr(longint'(atten_k[47:32]) * d2, 8);
        for (int i = 0; i < 3; i++) begin
            t = rnd_shr(longint'(lamp_color[16*i +: 16]) * longint'(lamp_gain), 8);
            t = rnd_shr(t * longint'(ndl), 14);
            t = rnd_shr(t * fall, 14);
            if (den == 0) r = (t != 0) ? 64'hFFFF : 0;
            else r = (t << 16) / den;
            if (r > 64'hFFFF) r = 64'hFFFF;
            case (i)
                0: res.red = r[15:0];
                1: res.green = r[15:0];
                default: res.blue = r[15:0];
            endcase
        end
        return res;
    endfunction

    task automatic report(string what, t_shade got, t_shade want);
        if (o_errors < 20)
            $display("mismatch in %s: got %h %h %h %b, expected %h %h %h %b", what,
                got.red, got.green, got.blue, got.in_cone,
                want.red, want.green, want.blue, want.in_cone);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_shade got;
        t_shade want;
        if (!i_rst_n) begin
            lit_on     <= 1'b1;
            lamp_pos   <= '0;
            cone_axis  <= '0;
            lamp_color <= '0;
            lamp_gain  <= 16'd256;
            atten_k    <= 48'd256;
            reach      <= '0;
            cone_cos   <= '0;
            radiance_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) radiance_q.push_back(shade_point(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[15:0], i_m_tdata[31:16], i_m_tdata[47:32], i_m_tuser};
                if (radiance_q.size() == 0) begin
                    report("unexpected transfer", got, '0);
                end else begin
                    want = radiance_q.pop_front();
                    if (got.red != want.red) report("red", got, want);
                    if (got.green != want.green) report("green", got, want);
                    if (got.blue != want.blue) report("blue", got, want);
                    if (got.in_cone != want.in_cone) report("inside_cone", got, want);
                end
            end
            if (i_cfg_we) begin
                case (slr_pkg::t_cfg_idx'(i_cfg_addr))
                    slr_pkg::CFG_ENABLE:    lit_on     <= i_cfg_wdata[0];
                    slr_pkg::CFG_POSITION:  lamp_pos   <= i_cfg_wdata[47:0];
                    slr_pkg::CFG_AXIS:      cone_axis  <= i_cfg_wdata[47:0];
                    slr_pkg::CFG_COLOR:     lamp_color <= i_cfg_wdata[47:0];
                    slr_pkg::CFG_INTENSITY: lamp_gain  <= i_cfg_wdata[15:0];
                    slr_pkg::CFG_ATTEN:     atten_k    <= i_cfg_wdata[47:0];
                    slr_pkg::CFG_RANGE:     reach      <= i_cfg_wdata[15:0];
                    slr_pkg::CFG_CONES:     cone_cos   <= i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
        end
        o_pending <= radiance_q.size();
    end
endmodule

### verif/spot_light_radiance_tb.sv
module spot_light_radiance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [slr_pkg::IN_W-1:0]    i_s_tdata;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic [slr_pkg::OUT_W-1:0]   o_m_tdata;
    logic                        o_m_tuser;
    logic                        i_cfg_we;
    logic [slr_pkg::CFG_AW-1:0]  i_cfg_addr;
    logic [slr_pkg::CFG_W-1:0]   i_cfg_wdata;
    int                          mismatches;
    int                          in_flight;
    logic                        steady;
    int                          quiet_cycles;
    logic [47:0]                 lamp_at;

    spot_light_radiance u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    spot_light_radiance_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (mismatches),
        .o_pending   (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        steady      = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) i_m_tready <= steady || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(slr_pkg::t_cfg_idx idx, logic [47:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (in_flight != 0);
        @(posedge i_clk);
    endtask

    task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                              logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        while (!steady && $urandom_range(0, 99) < 10) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {nz, ny, nx, pz, py, px};
        do @(negedge i_clk); while (!o_s_tready);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] unit_val();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [15:0] near(logic [15:0] base);
        int spread;
        spread = ($urandom_range(0, 9) < 7) ? 4096 : 32767;
        return 16'(int'($signed(base)) + $urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic random_light(int kind);
        logic [15:0] outer;
        lamp_at = 48'({$urandom, $urandom});
        if (kind % 3 != 0) lamp_at = {near(16'd0), near(16'd0), near(16'd0)};
        write_reg(slr_pkg::CFG_ENABLE, (kind == 4) ? 48'd0 : 48'd1);
        write_reg(slr_pkg::CFG_POSITION, lamp_at);
        write_reg(slr_pkg::CFG_AXIS, {unit_val(), unit_val(), unit_val()});
        write_reg(slr_pkg::CFG_COLOR,
                  (kind == 7) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
        write_reg(slr_pkg::CFG_INTENSITY,
                  (kind == 7) ? 48'hFFFF : 48'($urandom_range(0, 2048)));
        if (kind == 5)
            write_reg(slr_pkg::CFG_ATTEN, 48'd0);
        else if (kind == 7)
            write_reg(slr_pkg::CFG_ATTEN, 48'hFFFF_FFFF_FFFF);
        else
            write_reg(slr_pkg::CFG_ATTEN, {16'($urandom_range(0, 64)),
                                           16'($urandom_range(0, 512)),
                                           16'($urandom_range(0, 512))});
        write_reg(slr_pkg::CFG_RANGE, ($urandom_range(0, 1) == 1) ? 48'd0 :
                  48'($urandom_range(1, 65535)));
        outer = 16'($urandom_range(0, 24576) - 16384);
        write_reg(slr_pkg::CFG_CONES, (kind == 8) ? 48'($urandom) :
                  48'({16'(int'($signed(outer)) + $urandom_range(0, 8192)), outer}));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        drain();
        write_reg(slr_pkg::CFG_POSITION, {16'h0A00, 16'h0000, 16'h0000});
        write_reg(slr_pkg::CFG_AXIS, {16'hC000, 16'h0000, 16'h0000});
        write_reg(slr_pkg::CFG_COLOR, {16'h0100, 16'h0200, 16'h0300});
        write_reg(slr_pkg::CFG_CONES, {16'h0000, 16'h3000, 16'h2000});
        i_cfg_we <= 1'b0;
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0000, 16'h0000, 16'h0A00, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
        send_point(16'h8000, 16'h8000, 16'h8000, 16'hC000, 16'hC000, 16'hC000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h4000, 16'h4000);
        send_point(16'h7FFF, 16'h8000, 16'h0000, 16'h4000, 16'h0000, 16'hC000);
        send_point(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h4000);
        drain();
        write_reg(slr_pkg::CFG_RANGE, 48'h0500);
        write_reg(slr_pkg::CFG_INTENSITY, 48'hFFFF);
        i_cfg_we <= 1'b0;
        send_point(16'h0000, 16'h0000, 16'h0600, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0000, 16'h0000, 16'h0500, 16'h0000, 16'h0000, 16'h4000);
        drain();
        write_reg(slr_pkg::CFG_ATTEN, 48'd0);
        write_reg(slr_pkg::CFG_RANGE, 48'd0);
        i_cfg_we <= 1'b0;
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_point(16'h0000, 16'h0000, 16'h0A00, 16'h0000, 16'h0000, 16'h4000);
        drain();
        write_reg(slr_pkg::CFG_ENABLE, 48'd0);
        i_cfg_we <= 1'b0;
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            random_light(ph);
            steady <= (ph == 6);
            for (int k = 0; k < 125; k++) begin
                if ($urandom_range(0, 9) < 8)
                    send_point(near(lamp_at[15:0]), near(lamp_at[31:16]),
                               near(lamp_at[47:32]), unit_val(), unit_val(), unit_val());
                else
                    send_point(16'($urandom), 16'($urandom), 16'($urandom),
                               unit_val(), unit_val(), unit_val());
            end
            i_s_tvalid <= 1'b0;
            drain();
        end

        steady <= 1'b0;
        repeat (slr_pkg::LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
